[design/lfsp_pkg.sv]
// Shared types, constants and alignment helpers for the free span picker.
`timescale 1ns / 1ps

package lfsp_pkg;

  // Field widths
  localparam int ADDR_W    = 64;
  localparam int PAGES_W   = 52;
  localparam int KIND_W    = 4;
  localparam int CFG_IDX_W = 2;

  // Page geometry (power of two)
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

  localparam logic [KIND_W-1:0] CONVENTIONAL_KIND = KIND_W'(7);
  localparam logic [ADDR_W-1:0] DEFAULT_IMAGE_END = 64'h0000_0000_0010_0000;
  localparam logic [ADDR_W-1:0] DEFAULT_MIN_CLAIM = 64'h0000_0000_0020_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_START = 2'd0,
    REG_IMAGE_LIMIT = 2'd1,
    REG_MIN_CLAIM   = 2'd2
  } cfg_reg_t;

  // Derived image bounds handed from the config block to the datapath
  typedef struct packed {
    logic [ADDR_W-1:0] ibase;     // image base (end when base unknown)
    logic [ADDR_W-1:0] ibase_dn;  // image base rounded down to a page
    logic [ADDR_W-1:0] iend;      // page-aligned image end
    logic              carve_en;  // image end above image base
    logic [ADDR_W-1:0] min_claim; // smallest accepted candidate
  } bounds_t;

  function automatic logic [ADDR_W-1:0] align_up(input logic [ADDR_W-1:0] v);
    return (v + PAGE_MASK) & ~PAGE_MASK;
  endfunction

  function automatic logic [ADDR_W-1:0] align_down(input logic [ADDR_W-1:0] v);
    return v & ~PAGE_MASK;
  endfunction

endpackage

[design/lfsp_cfg.sv]
// Configuration registers and the derived image bounds.
`timescale 1ns / 1ps

module lfsp_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lfsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfsp_pkg::ADDR_W-1:0]        cfg_wdata,
  output lfsp_pkg::bounds_t                  bounds
);

  logic [lfsp_pkg::ADDR_W-1:0] image_start;
  logic [lfsp_pkg::ADDR_W-1:0] image_limit;
  logic [lfsp_pkg::ADDR_W-1:0] min_claim;
  logic [lfsp_pkg::ADDR_W-1:0] iend;
  logic [lfsp_pkg::ADDR_W-1:0] ibase;
  logic [lfsp_pkg::ADDR_W-1:0] ibase_dn;
  logic                        carve_en;
  logic [lfsp_pkg::ADDR_W-1:0] ibase_next;

  // Write the addressed register; drop writes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      image_start <= '0;
      image_limit <= '0;
      min_claim   <= lfsp_pkg::DEFAULT_MIN_CLAIM;
    end else if (cfg_we) begin
      case (cfg_index)
        lfsp_pkg::REG_IMAGE_START: image_start <= cfg_wdata;
        lfsp_pkg::REG_IMAGE_LIMIT: image_limit <= cfg_wdata;
        lfsp_pkg::REG_MIN_CLAIM:   min_claim   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pick the base: unknown base falls back to the image end
  always_comb begin
    ibase_next = (image_start == '0) ? iend : image_start;
  end

  // Derive bounds in two steps: end first, then base and carve enable
  always_ff @(posedge clk) begin
    if (rst) begin
      iend     <= lfsp_pkg::align_up(lfsp_pkg::DEFAULT_IMAGE_END);
      ibase    <= lfsp_pkg::align_up(lfsp_pkg::DEFAULT_IMAGE_END);
      ibase_dn <= lfsp_pkg::align_up(lfsp_pkg::DEFAULT_IMAGE_END);
      carve_en <= 1'b0;
    end else begin
      iend     <= lfsp_pkg::align_up((image_limit == '0) ?
                                     lfsp_pkg::DEFAULT_IMAGE_END : image_limit);
      ibase    <= ibase_next;
      ibase_dn <= lfsp_pkg::align_down(ibase_next);
      carve_en <= (image_start != '0) && (iend > image_start);
    end
  end

  assign bounds.ibase     = ibase;
  assign bounds.ibase_dn  = ibase_dn;
  assign bounds.iend      = iend;
  assign bounds.carve_en  = carve_en;
  assign bounds.min_claim = min_claim;

endmodule

[design/largest_free_span_picker_unit.sv]
// Top level of the largest free span picker: descriptor pipeline and running best.
`timescale 1ns / 1ps

// Takes one memory-map descriptor beat per clock while s_tready is high
// and, on the beat marked tlast, returns one result beat with the largest
// usable page-aligned span seen since the previous last beat (address and
// length in m_tdata, found in m_tuser), then starts over. Descriptors flow
// through a five-register pipeline (input, end/align, carve compares,
// candidate select, running-best update), and the sustained rate is one
// descriptor per cycle while the update stage is not held. A result
// waiting on m_tready holds only the update stage, and only once another
// last descriptor reaches it; descriptors before that keep flowing. The
// image bounds derived from a configuration write settle first in the end
// register and then in the base and carve-enable registers.
module largest_free_span_picker_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [lfsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfsp_pkg::ADDR_W-1:0]       cfg_wdata,
  // descriptor stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [119:0]                      s_tdata,  // span_start[63:0], page_count[115:64]
  input  logic [lfsp_pkg::KIND_W-1:0]       s_tuser,  // desc_kind[3:0]
  input  logic                              s_tlast,  // last_desc
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [127:0]                      m_tdata,  // pick_addr[63:0], pick_len[127:64]
  output logic                              m_tuser   // found
);

  localparam int AW = lfsp_pkg::ADDR_W;

  lfsp_pkg::bounds_t bounds;

  lfsp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .bounds    (bounds)
  );

  // Stage 1: input register
  logic                          p1_valid;
  logic                          p1_elig;
  logic                          p1_last;
  logic [AW-1:0]                 p1_start;
  logic [lfsp_pkg::PAGES_W-1:0]  p1_pages;

  // Stage 2: end address and rounded-up start
  logic          p2_valid;
  logic          p2_elig;
  logic          p2_last;
  logic [AW-1:0] p2_start;
  logic [AW-1:0] p2_end;
  logic [AW-1:0] p2_a_up;

  // Stage 3: carve compares and piece lengths
  logic          p3_valid;
  logic          p3_elig;
  logic          p3_last;
  logic          p3_ov;
  logic          p3_left_ok;
  logic          p3_right_ok;
  logic          p3_plain_ok;
  logic [AW-1:0] p3_a_up;
  logic [AW-1:0] p3_left_len;
  logic [AW-1:0] p3_right_len;
  logic [AW-1:0] p3_plain_len;

  // Stage 4: chosen candidate
  logic          p4_valid;
  logic          p4_last;
  logic [AW-1:0] p4_addr;
  logic [AW-1:0] p4_len;

  // Running best
  logic [AW-1:0] top_addr;
  logic [AW-1:0] top_len;

  logic          out_free;
  logic          fire4;
  logic          rdy1, rdy2, rdy3, rdy4;
  logic [AW-1:0] end_dn;
  logic [AW-1:0] left_len_eff;
  logic [AW-1:0] left_addr_eff;
  logic [AW-1:0] sel_addr;
  logic [AW-1:0] sel_len;
  logic          take;
  logic [AW-1:0] top_addr_next;
  logic [AW-1:0] top_len_next;
  logic          found_next;

  // Elastic ready chain: a stage loads when it is empty or moving on
  always_comb begin
    out_free = !m_tvalid || m_tready;
    fire4    = p4_valid && (!p4_last || out_free);
    rdy4     = !p4_valid || fire4;
    rdy3     = !p3_valid || rdy4;
    rdy2     = !p2_valid || rdy3;
    rdy1     = !p1_valid || rdy2;
  end

  assign s_tready = rdy1;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      if (rdy1) p1_valid <= s_tvalid;
      if (rdy2) p2_valid <= p1_valid;
      if (rdy3) p3_valid <= p2_valid;
      if (rdy4) p4_valid <= p3_valid;
    end
  end

  // Stage 1: capture the beat
  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_start <= s_tdata[AW-1:0];
      p1_pages <= s_tdata[AW +: lfsp_pkg::PAGES_W];
      p1_last  <= s_tlast;
      p1_elig  <= (s_tuser == lfsp_pkg::CONVENTIONAL_KIND) &&
                  (s_tdata[AW +: lfsp_pkg::PAGES_W] != '0);
    end
  end

  // Stage 2: end address wraps modulo 2^64
  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_elig  <= p1_elig;
      p2_last  <= p1_last;
      p2_start <= p1_start;
      p2_end   <= p1_start + (AW'(p1_pages) << lfsp_pkg::PAGE_SHIFT);
      p2_a_up  <= lfsp_pkg::align_up(p1_start);
    end
  end

  // Stage 3: overlap test and lengths of left, right and plain pieces
  assign end_dn = lfsp_pkg::align_down(p2_end);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      p3_elig      <= p2_elig;
      p3_last      <= p2_last;
      p3_a_up      <= p2_a_up;
      p3_ov        <= bounds.carve_en && (p2_start < bounds.iend) &&
                      (p2_end > bounds.ibase);
      p3_left_ok   <= (p2_start < bounds.ibase) && (bounds.ibase_dn > p2_a_up);
      p3_left_len  <= bounds.ibase_dn - p2_a_up;
      p3_right_ok  <= (p2_end > bounds.iend) && (end_dn > bounds.iend);
      p3_right_len <= end_dn - bounds.iend;
      p3_plain_ok  <= end_dn > p2_a_up;
      p3_plain_len <= end_dn - p2_a_up;
    end
  end

  // Select the candidate; left piece wins a tie
  always_comb begin
    left_len_eff  = p3_left_ok ? p3_left_len : '0;
    left_addr_eff = p3_left_ok ? p3_a_up : '0;
    sel_addr      = '0;
    sel_len       = '0;
    if (p3_elig) begin
      if (p3_ov) begin
        if (p3_right_ok && (p3_right_len > left_len_eff)) begin
          sel_addr = bounds.iend;
          sel_len  = p3_right_len;
        end else begin
          sel_addr = left_addr_eff;
          sel_len  = left_len_eff;
        end
      end else if (p3_plain_ok) begin
        sel_addr = p3_a_up;
        sel_len  = p3_plain_len;
      end
    end
  end

  // Stage 4: hold the candidate
  always_ff @(posedge clk) begin
    if (rdy4) begin
      p4_last <= p3_last;
      p4_addr <= sel_addr;
      p4_len  <= sel_len;
    end
  end

  // Keep a candidate that meets the minimum and beats the best
  always_comb begin
    take          = (p4_len >= bounds.min_claim) && (p4_len > top_len);
    top_addr_next = take ? p4_addr : top_addr;
    top_len_next  = take ? p4_len : top_len;
    found_next    = (take || (top_len >= bounds.min_claim)) && (top_addr_next != '0);
  end

  // Update the running best; clear it after the last descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      top_addr <= '0;
      top_len  <= '0;
    end else if (fire4) begin
      if (p4_last) begin
        top_addr <= '0;
        top_len  <= '0;
      end else begin
        top_addr <= top_addr_next;
        top_len  <= top_len_next;
      end
    end
  end

  // Result register: load on the last descriptor, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire4 && p4_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire4 && p4_last) begin
      m_tdata <= {top_len_next, top_addr_next};
      m_tuser <= found_next;
    end
  end

endmodule

[bench/tb_largest_free_span_picker_unit.sv]
// Self-checking testbench for the largest free span picker unit.
`timescale 1ns / 1ps

module tb_largest_free_span_picker_unit;

  localparam int CYCLE_LIMIT = 200000;

  // One memory-map descriptor as it goes onto the slave stream
  typedef struct {
    logic [lfsp_pkg::KIND_W-1:0]  kind;
    logic [lfsp_pkg::ADDR_W-1:0]  start;
    logic [lfsp_pkg::PAGES_W-1:0] pages;
    logic                         last;
  } span_desc_t;

  // One expected pick beat
  typedef struct {
    logic [lfsp_pkg::ADDR_W-1:0] addr;
    logic [lfsp_pkg::ADDR_W-1:0] len;
    logic                        found;
  } span_pick_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [lfsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lfsp_pkg::ADDR_W-1:0]    cfg_wdata = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [119:0]                   s_tdata = '0;   // span_start[63:0], page_count[115:64]
  logic [lfsp_pkg::KIND_W-1:0]    s_tuser = '0;   // desc_kind[3:0]
  logic                           s_tlast = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [127:0]                   m_tdata;        // pick_addr[63:0], pick_len[127:64]
  logic                           m_tuser;        // found

  // Shadow of the configuration and the running best
  logic [lfsp_pkg::ADDR_W-1:0] img_start = '0;
  logic [lfsp_pkg::ADDR_W-1:0] img_limit = '0;
  logic [lfsp_pkg::ADDR_W-1:0] min_claim = lfsp_pkg::DEFAULT_MIN_CLAIM;
  logic [lfsp_pkg::ADDR_W-1:0] top_addr = '0;
  logic [lfsp_pkg::ADDR_W-1:0] top_len = '0;

  span_desc_t desc_q[$];
  span_pick_t pick_q[$];
  int         send_idle = 0;
  int         recv_idle = 0;
  int         err_cnt = 0;
  int         cycle_cnt = 0;

  largest_free_span_picker_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Fold one descriptor into the running best; emit a pick on the last one
  function automatic void predict_pick(input logic [lfsp_pkg::KIND_W-1:0] kind,
                                       input logic [lfsp_pkg::ADDR_W-1:0] start,
                                       input logic [lfsp_pkg::PAGES_W-1:0] pages,
                                       input logic last);
    logic [lfsp_pkg::ADDR_W-1:0] iend;
    logic [lfsp_pkg::ADDR_W-1:0] ibase;
    logic [lfsp_pkg::ADDR_W-1:0] stop;
    logic [lfsp_pkg::ADDR_W-1:0] lo;
    logic [lfsp_pkg::ADDR_W-1:0] hi;
    logic [lfsp_pkg::ADDR_W-1:0] sel_addr;
    logic [lfsp_pkg::ADDR_W-1:0] sel_len;
    span_pick_t                  res;
    if (kind == lfsp_pkg::CONVENTIONAL_KIND && pages != '0) begin
      iend = (img_limit == '0) ? lfsp_pkg::DEFAULT_IMAGE_END : img_limit;
      iend = (iend + lfsp_pkg::PAGE_MASK) & ~lfsp_pkg::PAGE_MASK;
      ibase = (img_start == '0) ? iend : img_start;
      stop = start + ({{(lfsp_pkg::ADDR_W-lfsp_pkg::PAGES_W){1'b0}}, pages}
                      << lfsp_pkg::PAGE_SHIFT);
      sel_addr = '0;
      sel_len = '0;
      if (iend > ibase && start < iend && stop > ibase) begin
        // carve around the image, left piece wins a tie
        if (start < ibase) begin
          lo = (start + lfsp_pkg::PAGE_MASK) & ~lfsp_pkg::PAGE_MASK;
          hi = ibase & ~lfsp_pkg::PAGE_MASK;
          if (hi > lo) begin
            sel_addr = lo;
            sel_len = hi - lo;
          end
        end
        if (stop > iend) begin
          lo = (iend + lfsp_pkg::PAGE_MASK) & ~lfsp_pkg::PAGE_MASK;
          hi = stop & ~lfsp_pkg::PAGE_MASK;
          if (hi > lo && (hi - lo) > sel_len) begin
            sel_addr = lo;
            sel_len = hi - lo;
          end
        end
      end else begin
        lo = (start + lfsp_pkg::PAGE_MASK) & ~lfsp_pkg::PAGE_MASK;
        hi = stop & ~lfsp_pkg::PAGE_MASK;
        if (hi > lo) begin
          sel_addr = lo;
          sel_len = hi - lo;
        end
      end
      if (sel_len >= min_claim && sel_len > top_len) begin
        top_addr = sel_addr;
        top_len = sel_len;
      end
    end
    if (last) begin
      res.addr = top_addr;
      res.len = top_len;
      res.found = (top_len >= min_claim && top_addr != '0);
      pick_q.push_back(res);
      top_addr = '0;
      top_len = '0;
    end
  endfunction

  task automatic push_desc(input logic [lfsp_pkg::KIND_W-1:0] kind,
                           input logic [lfsp_pkg::ADDR_W-1:0] start,
                           input logic [lfsp_pkg::PAGES_W-1:0] pages,
                           input logic last);
    span_desc_t d;
    d.kind = kind;
    d.start = start;
    d.pages = pages;
    d.last = last;
    desc_q.push_back(d);
  endtask

  // Queue random maps until enough descriptors that the block considers
  task automatic fill_maps(input int count);
    int                           got;
    int                           n;
    bit                           noise;
    logic [lfsp_pkg::KIND_W-1:0]  kind;
    logic [lfsp_pkg::ADDR_W-1:0]  start;
    logic [lfsp_pkg::PAGES_W-1:0] pages;
    int                           r;
    got = 0;
    while (got < count) begin
      noise = ($urandom_range(9) == 0);
      n = noise ? 1 : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        kind = ($urandom_range(99) < 70) ? lfsp_pkg::CONVENTIONAL_KIND
                                         : lfsp_pkg::KIND_W'($urandom);
        case ($urandom_range(5))
          0: start = {$urandom, $urandom};
          1: start = {32'h0, $urandom & 32'h0FFF_FFFF};
          2: start = img_start - lfsp_pkg::ADDR_W'($urandom_range(32'h40_0000))
                     + lfsp_pkg::ADDR_W'($urandom_range(32'h10_0000));
          3: start = img_limit - lfsp_pkg::ADDR_W'($urandom_range(32'h40_0000))
                     + lfsp_pkg::ADDR_W'($urandom_range(32'h10_0000));
          4: start = 64'hFFFF_FFFF_FFFF_FFFF
                     - lfsp_pkg::ADDR_W'($urandom_range(32'h00FF_FFFF));
          default: start = {32'h0, $urandom & 32'h3FFF_F000};
        endcase
        r = $urandom_range(99);
        if (r < 5) pages = '0;
        else if (r < 65) pages = lfsp_pkg::PAGES_W'($urandom_range(1, 32'h800));
        else if (r < 90) pages = lfsp_pkg::PAGES_W'($urandom_range(1, 32'h10_0000));
        else pages = lfsp_pkg::PAGES_W'({$urandom, $urandom});
        push_desc(kind, start, pages, noise ? 1'($urandom) : (i == n - 1));
        if (kind == lfsp_pkg::CONVENTIONAL_KIND && pages != '0) got++;
      end
    end
  endtask

  task automatic write_reg(input lfsp_pkg::cfg_reg_t idx,
                           input logic [lfsp_pkg::ADDR_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      lfsp_pkg::REG_IMAGE_START: img_start = val;
      lfsp_pkg::REG_IMAGE_LIMIT: img_limit = val;
      lfsp_pkg::REG_MIN_CLAIM:   min_claim = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued beat is taken and every pick has come back
  task automatic wait_drained();
    do @(negedge clk); while (desc_q.size() != 0 || s_tvalid || pick_q.size() != 0);
  endtask

  // Sequence: reset, then per phase: settle (not first), configure, two bursts of maps
  initial begin
    logic [lfsp_pkg::ADDR_W-1:0] cs;
    logic [lfsp_pkg::ADDR_W-1:0] cl;
    logic [lfsp_pkg::ADDR_W-1:0] cm;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_drained();
        repeat (8) @(posedge clk);
      end
      case (p)
        0: begin cs = 64'h40_0000; cl = 64'h60_0800; cm = 64'h2000; end
        1: begin cs = '0; cl = '0; cm = lfsp_pkg::DEFAULT_MIN_CLAIM; end
        2: begin cs = 64'h7FFF_F000_0000_0ABC; cl = 64'h8000_0000_0123_4567; cm = '0; end
        3: begin cs = '1; cl = '1; cm = '1; end
        4: begin cs = 64'h1000; cl = '0; cm = 64'h1000; end
        default: begin cs = 64'h8000_0000; cl = 64'hC000_0001; cm = 64'h10_0000; end
      endcase
      write_reg(lfsp_pkg::REG_IMAGE_START, cs);
      write_reg(lfsp_pkg::REG_IMAGE_LIMIT, cl);
      write_reg(lfsp_pkg::REG_MIN_CLAIM, cm);
      // let the derived bounds settle after the writes
      repeat (4) @(posedge clk);
      @(negedge clk);
      send_idle = (p < 2) ? 23 : (p < 4) ? 48 : 0;
      recv_idle = (p < 2) ? 48 : (p < 4) ? 23 : 0;
      if (p == 0) begin
        // empty map
        push_desc(4'd0, '0, '0, 1'b1);
        // an aligned span, then an ignored kind, zero pages and a shorter unaligned span
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h1000_0000, 52'h100, 1'b0);
        push_desc(4'd3, 64'h1000_0000, 52'h1_0000, 1'b0);
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h1000_0000, 52'h0, 1'b0);
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h2000_0800, 52'h20, 1'b1);
        // overlap with the image: left piece, then right piece
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h10_0000, 52'h400, 1'b1);
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h3F_F000, 52'h1000, 1'b1);
        // equal pieces on both sides, exactly the minimum
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h3F_E000, 52'h205, 1'b1);
        // end address wraps past the top
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'hFFFF_FFFF_FFFF_0000, 52'h20, 1'b1);
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'hFFFF_FFFF_FFF0_0001, 52'hFF, 1'b1);
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'hFFFF_FFFF_FFFF_FFFF, 52'h1, 1'b1);
        // field extremes, last descriptor skipped
        push_desc(4'hF, '1, '1, 1'b0);
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, '0, '1, 1'b0);
        push_desc(4'hF, '1, '1, 1'b1);
        // zero address with a long enough span
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, '0, 52'h300, 1'b1);
        // below the minimum
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h1000_0000, 52'h1, 1'b1);
        // equal candidates keep the first, a longer one replaces it
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h2000_0000, 52'h10, 1'b0);
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h3000_0000, 52'h10, 1'b0);
        push_desc(lfsp_pkg::CONVENTIONAL_KIND, 64'h4000_0000, 52'h11, 1'b0);
        push_desc(4'd0, '0, '0, 1'b1);
      end
      fill_maps(77);
      // hold the sender until every pick is back
      wait_drained();
      fill_maps(77);
    end
    wait_drained();
    repeat (12) @(posedge clk);
    if (err_cnt == 0 && pick_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Drive descriptor beats, idling at random
  always @(posedge clk) begin
    span_desc_t d;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (desc_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        d = desc_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {4'h0, d.pages, d.start};
        s_tuser <= d.kind;
        s_tlast <= d.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result stream at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Predict on every accepted descriptor beat
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_pick(s_tuser, s_tdata[63:0], s_tdata[115:64], s_tlast);
    end
  end

  // Check every accepted pick beat against the oldest prediction
  always @(posedge clk) begin
    span_pick_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pick_q.size() == 0) begin
        $error("pick beat with none expected: addr %h len %h found %b",
               m_tdata[63:0], m_tdata[127:64], m_tuser);
        err_cnt++;
      end else begin
        want = pick_q.pop_front();
        if (m_tdata[63:0] !== want.addr) begin
          $error("pick_addr mismatch: expected %h, got %h", want.addr, m_tdata[63:0]);
          err_cnt++;
        end
        if (m_tdata[127:64] !== want.len) begin
          $error("pick_len mismatch: expected %h, got %h", want.len, m_tdata[127:64]);
          err_cnt++;
        end
        if (m_tuser !== want.found) begin
          $error("found mismatch: expected %b, got %b", want.found, m_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
